### design/rc6_pkg.sv
// Package for the RC6 block cipher: constants, command and status codes.
package rc6_pkg;

  localparam logic [31:0] MagicP = 32'hB7E15163;
  localparam logic [31:0] MagicQ = 32'h9E3779B9;

  // Commands
  localparam logic [1:0] CmdExpand  = 2'd0;
  localparam logic [1:0] CmdEncrypt = 2'd1;
  localparam logic [1:0] CmdDecrypt = 2'd2;

  // Status codes
  localparam logic [1:0] StsBlock  = 2'd0;
  localparam logic [1:0] StsKey    = 2'd1;
  localparam logic [1:0] StsReject = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;
  localparam logic [1:0] RegRounds  = 2'd2;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage

### design/rc6_skmem.sv
// Subkey memory: one write port, one read port, registered read data.
module rc6_skmem
  import rc6_pkg::*;
#(
  parameter int unsigned Depth = 44,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/rc6_block_cipher.sv
// RC6 top level: command sequencer, key schedule and shared round unit.
// Encrypt/decrypt: subkey pairs are read a word at a time on the single memory
//   read port, r + 2 pairs in all; each pair is applied once both words are in.
// Key expansion: 2r+4 fill writes, then 3*(2r+4) mix steps of a read state and
//   a write state each, then one status state before the result is valid.
// One item at a time: the input is ready again once the result is taken.
// Reset clears control state and key_ready; subkeys are undefined until expanded.
module rc6_block_cipher
  import rc6_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  output logic [1:0]  status_o
);

  localparam int unsigned Depth = 2 * MAX_ROUNDS + 4;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned SW = $clog2(3 * Depth + 1);
  localparam int unsigned RW = 5;

  // States
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFill  = 3'd1;
  localparam logic [2:0] StMixRd = 3'd2;
  localparam logic [2:0] StMixWr = 3'd3;
  localparam logic [2:0] StCrypt = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [63:0]   key_high_q, key_low_q;
  logic [RW-1:0] rounds_q;
  logic          key_ready_q;
  logic [RW-1:0] r_eff;
  logic [RW-1:0] r_last;
  logic [AW:0]   t_len;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      rounds_q   <= RW'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKeyHigh: key_high_q <= cfg_data_i;
        RegKeyLow:  key_low_q  <= cfg_data_i;
        RegRounds:  rounds_q   <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  assign r_eff  = (rounds_q > RW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : rounds_q;
  assign r_last = r_eff + RW'(1);
  assign t_len  = (AW+1)'({r_eff, 1'b0}) + (AW+1)'(4);

  // Working registers
  logic        enc_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] la_q, lb_q;                // key schedule A and B
  logic [31:0] l_q [4];
  logic [AW-1:0] idx_q;                   // memory index i
  logic [1:0]  j_q;
  logic [SW-1:0] step_q;
  logic [31:0] fill_q;
  logic [RW-1:0] pr_q;                    // subkey pair being fetched
  logic [RW-1:0] ap_q;                    // pair being applied: 0 pre, r+1 final
  logic        sel_q;                     // which subkey of the pair is read
  logic        have_q;                    // a fetched pair is ready to apply
  logic [31:0] sk0_q;

  // Memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  rc6_skmem #(.Depth(Depth), .AddrW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Key schedule datapath
  logic [31:0] sk_new, l_sum, l_new;
  assign sk_new = rol32(rdata + la_q + lb_q, 5'd3);
  assign l_sum  = sk_new + lb_q;
  assign l_new  = rol32(l_q[j_q] + l_sum, l_sum[4:0]);

  // Round unit: f() on B and D for encrypt, on A and C (rotated in) for decrypt
  logic [31:0] mul_x, mul_y, prod_x, prod_y, f_x, f_y;
  assign mul_x  = enc_q ? b_q : a_q;
  assign mul_y  = enc_q ? d_q : c_q;
  assign prod_x = mul_x * {mul_x[30:0], 1'b1};
  assign prod_y = mul_y * {mul_y[30:0], 1'b1};
  assign f_x    = rol32(prod_x, 5'd5);
  assign f_y    = rol32(prod_y, 5'd5);

  // Subkey pair: k0 = first word read, k1 = second, arriving now
  logic [31:0] k0, k1;
  logic        apply;
  logic        fetch_last;
  assign k0         = sk0_q;
  assign k1         = rdata;
  assign apply      = (state_q == StCrypt) && !sel_q && have_q;
  assign fetch_last = enc_q ? (pr_q == r_last) : (pr_q == '0);

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = idx_q;
    wdata = sk_new;
    raddr = idx_q;
    unique case (state_q)
      StFill: begin
        we = 1'b1;
        wdata = fill_q;
        if ((AW+1)'(idx_q) == t_len - (AW+1)'(1)) state_d = StMixRd;
      end
      StMixRd: state_d = StMixWr;
      StMixWr: begin
        we = 1'b1;
        if (step_q == SW'(3 * t_len - 1)) state_d = StOut;
        else state_d = StMixRd;
      end
      StCrypt: raddr = AW'({pr_q, sel_q});
      default: ;
    endcase
  end

  // Output register
  logic        out_valid_q;
  logic [63:0] res_hi_q, res_lo_q;
  logic [1:0]  sts_q;
  logic        in_acc;

  assign in_ready_o    = (state_q == StIdle) && !out_valid_q;
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_hi_q;
  assign result_low_o  = res_lo_q;
  assign status_o      = sts_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      key_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (cmd_i == CmdExpand) state_q <= StFill;
            else if ((cmd_i == CmdEncrypt || cmd_i == CmdDecrypt) && key_ready_q)
              state_q <= StCrypt;
            else out_valid_q <= 1'b1;
          end
        end
        StOut: begin
          key_ready_q <= 1'b1;
          out_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        StCrypt: begin
          if (apply && ap_q == r_last) begin
            out_valid_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= state_d;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_hi_q <= '0;
          res_lo_q <= '0;
          sts_q    <= StsReject;
          enc_q    <= (cmd_i == CmdEncrypt);
          a_q <= block_high_i[63:32];
          b_q <= block_high_i[31:0];
          c_q <= block_low_i[63:32];
          d_q <= block_low_i[31:0];
          idx_q  <= '0;
          fill_q <= MagicP;
          la_q <= '0;
          lb_q <= '0;
          j_q  <= '0;
          step_q <= '0;
          sel_q  <= 1'b0;
          have_q <= 1'b0;
          ap_q   <= '0;
          pr_q   <= (cmd_i == CmdEncrypt) ? '0 : r_last;
          l_q[0] <= key_low_q[31:0];
          l_q[1] <= key_low_q[63:32];
          l_q[2] <= key_high_q[31:0];
          l_q[3] <= key_high_q[63:32];
        end
      end
      StFill: begin
        fill_q <= fill_q + MagicQ;
        idx_q  <= ((AW+1)'(idx_q) == t_len - (AW+1)'(1)) ? '0 : idx_q + AW'(1);
      end
      StMixWr: begin
        la_q <= sk_new;
        lb_q <= l_new;
        l_q[j_q] <= l_new;
        j_q <= j_q + 2'd1;
        step_q <= step_q + SW'(1);
        idx_q <= ((AW+1)'(idx_q) == t_len - (AW+1)'(1)) ? '0 : idx_q + AW'(1);
      end
      StOut: sts_q <= StsKey;
      StCrypt: begin
        sel_q <= !sel_q;
        if (sel_q) begin
          // Capture the first word; the second read is in flight
          sk0_q  <= rdata;
          have_q <= 1'b1;
          if (!fetch_last) pr_q <= enc_q ? pr_q + RW'(1) : pr_q - RW'(1);
        end else if (have_q) begin
          // Apply the completed pair
          ap_q <= ap_q + RW'(1);
          if (ap_q == '0) begin
            if (enc_q) begin
              b_q <= b_q + k0;
              d_q <= d_q + k1;
            end else begin
              a_q <= a_q - k0;
              c_q <= c_q - k1;
            end
          end else if (ap_q == r_last) begin
            if (enc_q) begin
              res_hi_q <= {a_q + k0, b_q};
              res_lo_q <= {c_q + k1, d_q};
            end else begin
              res_hi_q <= {a_q, b_q - k0};
              res_lo_q <= {c_q, d_q - k1};
            end
            sts_q <= StsBlock;
          end else if (enc_q) begin
            a_q <= b_q;
            b_q <= rol32(c_q ^ f_y, f_x[4:0]) + k1;
            c_q <= d_q;
            d_q <= rol32(a_q ^ f_x, f_y[4:0]) + k0;
          end else begin
            a_q <= ror32(d_q - k0, f_y[4:0]) ^ f_x;
            b_q <= a_q;
            c_q <= ror32(b_q - k1, f_x[4:0]) ^ f_y;
            d_q <= c_q;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
